// ===== rtl/lcag_pkg.sv =====
// ----------------------------------------------------------------------------
// lcag_pkg
// shared types, sizes and codes of the life grid core
// ----------------------------------------------------------------------------
`default_nettype none

package lcag_pkg;

    // grid size
    localparam int GRID_COLS  = 64;
    localparam int GRID_ROWS  = 64;
    localparam int COL_W      = $clog2(GRID_COLS);
    localparam int ROW_W      = $clog2(GRID_ROWS);
    localparam int CELL_TOTAL = GRID_ROWS * GRID_COLS;

    // field and register widths
    localparam int ACT_W     = 2;
    localparam int AREA_W    = 7;
    localparam int CNT_W     = 13;
    localparam int CFG_IDX_W = 1;

    // actions
    localparam logic [ACT_W-1:0] ACT_WRITE = 2'd0;
    localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd1;
    localparam logic [ACT_W-1:0] ACT_STEP  = 2'd2;
    localparam logic [ACT_W-1:0] ACT_READ  = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 1'd1;

    localparam logic [AREA_W-1:0] AREA_RESET = AREA_W'(64);

    typedef logic [GRID_COLS-1:0] t_row;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [ROW_W-1:0] cell_row;
        logic [COL_W-1:0] cell_col;
        logic             cell_value;
    } t_in;

    typedef struct packed {
        logic             read_value;
        logic             changed;
        logic [CNT_W-1:0] live_count;
    } t_out;

endpackage

`default_nettype wire

// ===== rtl/lcag_ram.sv =====
// ----------------------------------------------------------------------------
// lcag_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module lcag_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/life_cellular_automaton_grid_core.sv =====
// ----------------------------------------------------------------------------
// life_cellular_automaton_grid_core
// bounded game of life grid (B3/S23) with cell access and generation step
// ----------------------------------------------------------------------------
// The grid is kept one row per word in a ram, with a valid bit per row so
// that reset and clear take effect at once (a row never written reads as
// dead). Each accepted item gives one result. A cell write or read reads
// its row in S_ISSUE and uses it in S_GET, a clear goes straight to S_FIN.
// A generation step is done by one shared neighbour-count and rule unit
// that visits one cell per cycle over the active area; three row registers
// hold the old rows around the one being worked on and each new row is
// written back in place. A configuration write runs the same sweep to kill
// cells outside the new area and recount, and the block stalls its input
// for that time. The input is stalled while an item is at work and while a
// configuration write is offered; a finished result sits in the output
// register so the next item may be taken before it is collected.
// ----------------------------------------------------------------------------
`default_nettype none

module life_cellular_automaton_grid_core (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // item input
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire lcag_pkg::t_in                  i_in_item,
    // result output
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output lcag_pkg::t_out                      o_out_item,
    // configuration writes
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [lcag_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [lcag_pkg::AREA_W-1:0]    i_cfg_data
);

    // sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_ISSUE = 4'd1;  // read addressed row
    localparam logic [3:0] S_GET   = 4'd2;  // use addressed row
    localparam logic [3:0] S_LD0   = 4'd3;  // sweep set-up, read row 0
    localparam logic [3:0] S_LD1   = 4'd4;  // take row 0, read row 1
    localparam logic [3:0] S_LD2   = 4'd5;  // take row 1
    localparam logic [3:0] S_CELL  = 4'd6;  // one cell per cycle
    localparam logic [3:0] S_WB    = 4'd7;  // write new row back
    localparam logic [3:0] S_END   = 4'd8;  // sweep wrap-up
    localparam logic [3:0] S_FIN   = 4'd9;  // hand result to output register

    // life rule
    localparam logic [3:0] BIRTH_COUNT   = 4'd3;
    localparam logic [3:0] SURVIVE_COUNT = 4'd2;

    localparam int AW = lcag_pkg::AREA_W;
    localparam int CW = lcag_pkg::COL_W;
    localparam int RW = lcag_pkg::ROW_W;

    // control registers
    logic [3:0]                   r_state,  n_state;
    logic [AW-1:0]                r_act_w,  n_act_w;
    logic [AW-1:0]                r_act_h,  n_act_h;
    logic [lcag_pkg::CNT_W-1:0]   r_live,   n_live;
    logic [lcag_pkg::GRID_ROWS-1:0] r_row_ok, n_row_ok;
    logic                         r_rd_ok,  n_rd_ok;
    logic                         r_out_valid, n_out_valid;
    logic                         r_trim,   n_trim;

    // payload registers
    lcag_pkg::t_in                r_item,   n_item;
    logic                         r_hit,    n_hit;
    logic                         r_res_bit, n_res_bit;
    logic                         r_res_chg, n_res_chg;
    lcag_pkg::t_out               r_out,    n_out;
    logic [RW-1:0]                r_row,    n_row;
    logic [CW-1:0]                r_col,    n_col;
    lcag_pkg::t_row               r_prev,   n_prev;
    lcag_pkg::t_row               r_cur,    n_cur;
    lcag_pkg::t_row               r_nxt,    n_nxt;
    lcag_pkg::t_row               r_new,    n_new;
    logic [lcag_pkg::CNT_W-1:0]   r_cnt,    n_cnt;
    logic                         r_diff,   n_diff;

    // ram port
    logic                         ram_we;
    logic [RW-1:0]                ram_waddr;
    lcag_pkg::t_row               ram_wdata;
    logic                         ram_re;
    logic [RW-1:0]                ram_raddr;
    lcag_pkg::t_row               ram_q;

    // derived values
    logic [AW-1:0]  eff_w;
    logic [AW-1:0]  eff_h;
    logic           area_empty;
    logic           in_hit;
    lcag_pkg::t_row row_eff;
    lcag_pkg::t_row wr_row;
    logic           get_bit;
    logic [AW-1:0]  row_plus1;
    logic [AW-1:0]  row_plus2;
    logic           have_r2;
    logic           last_col;
    logic [CW-1:0]  col_l;
    logic [CW-1:0]  col_r;
    logic           at_left;
    logic           at_right;
    logic [3:0]     nb_sum;
    logic           cur_bit;
    logic           step_bit;
    logic           new_bit;

    lcag_ram #(
        .WIDTH (lcag_pkg::GRID_COLS),
        .DEPTH (lcag_pkg::GRID_ROWS)
    ) u_grid_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    // active area saturates at the grid size
    assign eff_w = (r_act_w > AW'(lcag_pkg::GRID_COLS)) ? AW'(lcag_pkg::GRID_COLS) : r_act_w;
    assign eff_h = (r_act_h > AW'(lcag_pkg::GRID_ROWS)) ? AW'(lcag_pkg::GRID_ROWS) : r_act_h;
    assign area_empty = (eff_w == '0) || (eff_h == '0);

    assign in_hit = (AW'(i_in_item.cell_row) < eff_h) && (AW'(i_in_item.cell_col) < eff_w);

    // a row never written since reset or clear reads as all dead
    assign row_eff = r_rd_ok ? ram_q : '0;
    assign get_bit = row_eff[r_item.cell_col];

    always_comb begin
        wr_row = row_eff;
        wr_row[r_item.cell_col] = r_item.cell_value;
    end

    // sweep position
    assign row_plus1 = AW'(r_row) + AW'(1);
    assign row_plus2 = AW'(r_row) + AW'(2);
    assign have_r2   = row_plus2 < eff_h;
    assign last_col  = (AW'(r_col) == (eff_w - AW'(1)));

    // shared neighbour count and rule unit, off-grid neighbours are dead
    assign col_l    = r_col - CW'(1);
    assign col_r    = r_col + CW'(1);
    assign at_left  = (r_col == '0);
    assign at_right = (r_col == CW'(lcag_pkg::GRID_COLS - 1));
    assign cur_bit  = r_cur[r_col];

    assign nb_sum = 4'(r_prev[r_col])
                  + 4'(!at_left  && r_prev[col_l])
                  + 4'(!at_right && r_prev[col_r])
                  + 4'(!at_left  && r_cur[col_l])
                  + 4'(!at_right && r_cur[col_r])
                  + 4'(r_nxt[r_col])
                  + 4'(!at_left  && r_nxt[col_l])
                  + 4'(!at_right && r_nxt[col_r]);

    assign step_bit = (nb_sum == BIRTH_COUNT) || (cur_bit && (nb_sum == SURVIVE_COUNT));
    // trimming keeps every cell in the area as it is
    assign new_bit  = r_trim ? cur_bit : step_bit;

    // ports
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_in_stall  = (r_state != S_IDLE) || i_cfg_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    always_comb begin
        n_state     = r_state;
        n_act_w     = r_act_w;
        n_act_h     = r_act_h;
        n_live      = r_live;
        n_row_ok    = r_row_ok;
        n_rd_ok     = r_rd_ok;
        n_out_valid = r_out_valid && i_out_stall;
        n_trim      = r_trim;
        n_item      = r_item;
        n_hit       = r_hit;
        n_res_bit   = r_res_bit;
        n_res_chg   = r_res_chg;
        n_out       = r_out;
        n_row       = r_row;
        n_col       = r_col;
        n_prev      = r_prev;
        n_cur       = r_cur;
        n_nxt       = r_nxt;
        n_new       = r_new;
        n_cnt       = r_cnt;
        n_diff      = r_diff;
        ram_we      = 1'b0;
        ram_waddr   = r_row;
        ram_wdata   = r_new;
        ram_re      = 1'b0;
        ram_raddr   = r_row;

        case (r_state)
            S_IDLE: begin
                if (i_cfg_valid) begin
                    // new area, then sweep to trim and recount
                    case (i_cfg_index)
                        lcag_pkg::CFG_WIDTH:  n_act_w = i_cfg_data;
                        lcag_pkg::CFG_HEIGHT: n_act_h = i_cfg_data;
                        default: ;
                    endcase
                    n_trim  = 1'b1;
                    n_state = S_LD0;
                end else if (i_in_valid) begin
                    n_item = i_in_item;
                    n_hit  = in_hit;
                    case (i_in_item.action)
                        lcag_pkg::ACT_WRITE,
                        lcag_pkg::ACT_READ: begin
                            n_state = S_ISSUE;
                        end
                        lcag_pkg::ACT_CLEAR: begin
                            n_row_ok  = '0;
                            n_live    = '0;
                            n_res_bit = 1'b0;
                            n_res_chg = 1'b0;
                            n_state   = S_FIN;
                        end
                        lcag_pkg::ACT_STEP: begin
                            n_trim  = 1'b0;
                            n_state = S_LD0;
                        end
                        default: begin
                            n_state = S_FIN;
                        end
                    endcase
                end
            end

            S_ISSUE: begin
                ram_re    = 1'b1;
                ram_raddr = r_item.cell_row;
                n_rd_ok   = r_row_ok[r_item.cell_row];
                n_state   = S_GET;
            end

            S_GET: begin
                n_res_chg = (r_item.action == lcag_pkg::ACT_STEP) ? r_diff : 1'b0;
                if (r_item.action == lcag_pkg::ACT_WRITE) begin
                    n_res_bit = r_hit && r_item.cell_value;
                    if (r_hit) begin
                        // read-modify-write of the row, outside the area is ignored
                        ram_we    = 1'b1;
                        ram_waddr = r_item.cell_row;
                        ram_wdata = wr_row;
                        n_row_ok[r_item.cell_row] = 1'b1;
                        if (get_bit != r_item.cell_value) begin
                            n_live = r_item.cell_value ? r_live + lcag_pkg::CNT_W'(1)
                                                       : r_live - lcag_pkg::CNT_W'(1);
                        end
                    end
                end else begin
                    n_res_bit = r_hit && get_bit;
                end
                n_state = S_FIN;
            end

            S_LD0: begin
                n_prev = '0;
                n_row  = '0;
                n_col  = '0;
                n_cnt  = '0;
                n_diff = 1'b0;
                n_new  = '0;
                if (area_empty) begin
                    n_state = S_END;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = '0;
                    n_rd_ok   = r_row_ok[0];
                    n_state   = S_LD1;
                end
            end

            S_LD1: begin
                n_cur = row_eff;
                if (eff_h > AW'(1)) begin
                    ram_re    = 1'b1;
                    ram_raddr = RW'(1);
                    n_rd_ok   = r_row_ok[1];
                end
                n_state = S_LD2;
            end

            S_LD2: begin
                n_nxt   = (eff_h > AW'(1)) ? row_eff : '0;
                n_state = S_CELL;
            end

            S_CELL: begin
                // fetch the row below the next one while this row runs
                if (at_left && have_r2) begin
                    ram_re    = 1'b1;
                    ram_raddr = r_row + RW'(2);
                    n_rd_ok   = r_row_ok[r_row + RW'(2)];
                end
                n_new[r_col] = new_bit;
                n_cnt        = r_cnt + lcag_pkg::CNT_W'(new_bit);
                n_diff       = r_diff || (new_bit != cur_bit);
                if (last_col) begin
                    n_state = S_WB;
                end else begin
                    n_col = r_col + CW'(1);
                end
            end

            S_WB: begin
                // old row is still held in r_cur, so writing in place is safe
                ram_we    = 1'b1;
                ram_waddr = r_row;
                ram_wdata = r_new;
                n_row_ok[r_row] = 1'b1;
                n_prev = r_cur;
                n_cur  = r_nxt;
                n_nxt  = have_r2 ? row_eff : '0;
                n_new  = '0;
                n_col  = '0;
                if (row_plus1 == eff_h) begin
                    n_state = S_END;
                end else begin
                    n_row   = r_row + RW'(1);
                    n_state = S_CELL;
                end
            end

            S_END: begin
                n_live = r_cnt;
                if (r_trim) begin
                    // rows below the new area die
                    for (int i = 0; i < lcag_pkg::GRID_ROWS; i++) begin
                        n_row_ok[i] = r_row_ok[i] && !area_empty && (AW'(i) < eff_h);
                    end
                    n_state = S_IDLE;
                end else begin
                    n_state = S_ISSUE;
                end
            end

            S_FIN: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid      = 1'b1;
                    n_out.read_value = r_res_bit;
                    n_out.changed    = r_res_chg;
                    n_out.live_count = r_live;
                    n_state          = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_act_w     <= lcag_pkg::AREA_RESET;
            r_act_h     <= lcag_pkg::AREA_RESET;
            r_live      <= '0;
            r_row_ok    <= '0;
            r_rd_ok     <= 1'b0;
            r_out_valid <= 1'b0;
            r_trim      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_act_w     <= n_act_w;
            r_act_h     <= n_act_h;
            r_live      <= n_live;
            r_row_ok    <= n_row_ok;
            r_rd_ok     <= n_rd_ok;
            r_out_valid <= n_out_valid;
            r_trim      <= n_trim;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item    <= n_item;
        r_hit     <= n_hit;
        r_res_bit <= n_res_bit;
        r_res_chg <= n_res_chg;
        r_out     <= n_out;
        r_row     <= n_row;
        r_col     <= n_col;
        r_prev    <= n_prev;
        r_cur     <= n_cur;
        r_nxt     <= n_nxt;
        r_new     <= n_new;
        r_cnt     <= n_cnt;
        r_diff    <= n_diff;
    end

endmodule

`default_nettype wire

// ===== rtl/lcag_checker.sv =====
// ----------------------------------------------------------------------------
// lcag_checker
// port-level checks of the life grid core, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module lcag_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           i_in_valid,
    input wire logic                           o_in_stall,
    input wire lcag_pkg::t_in                  i_in_item,
    input wire logic                           o_out_valid,
    input wire logic                           i_out_stall,
    input wire lcag_pkg::t_out                 o_out_item,
    input wire logic                           i_cfg_valid,
    input wire logic                           o_cfg_ready
);

    logic                          r_held;
    logic [lcag_pkg::ACT_W-1:0]    r_last_act;
    logic                          in_xfer;
    logic                          out_new;
    logic                          cfg_xfer;

    assign in_xfer  = i_in_valid && !o_in_stall;
    assign cfg_xfer = i_cfg_valid && o_cfg_ready;
    // a result shown for the first time belongs to the last item taken
    assign out_new  = o_out_valid && !r_held;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held     <= 1'b0;
            r_last_act <= lcag_pkg::ACT_READ;
        end else begin
            r_held <= o_out_valid && i_out_stall;
            if (in_xfer) begin
                r_last_act <= i_in_item.action;
            end
        end
    end

    // one item at a time
    a_busy_after_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> o_in_stall)
        else $error("input taken again right after an item transfer");

    // configuration write starts a trim sweep
    a_busy_after_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_xfer |=> (o_in_stall && !o_cfg_ready))
        else $error("block idle right after a configuration transfer");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_item)))
        else $error("stalled result dropped or changed");

    a_changed_only_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_new && (r_last_act != lcag_pkg::ACT_STEP)) |-> !o_out_item.changed)
        else $error("changed flag set on an action that is not a step");

    a_clear_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_new && (r_last_act == lcag_pkg::ACT_CLEAR))
            |-> ((o_out_item.live_count == '0) && !o_out_item.read_value))
        else $error("grid not empty after clear");

endmodule

bind life_cellular_automaton_grid_core lcag_checker u_lcag_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item),
    .i_cfg_valid (i_cfg_valid),
    .o_cfg_ready (o_cfg_ready)
);

`default_nettype wire

// ===== sim/tb_life_cellular_automaton_grid_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_life_cellular_automaton_grid_core
// self-checking bench for the bounded game of life grid core
// ----------------------------------------------------------------------------
// Cell operations are queued by the stimulus block and offered by a driver on
// the falling edge. A monitor on the rising edge keeps its own copy of the
// grid, the live count and the area registers, predicts one result for every
// accepted operation and checks each result transfer against the oldest
// prediction. The run starts with a directed sequence on the full grid, then
// moves through several active area settings (empty, one wide, one high,
// saturated, small) with random traffic and varying idle and stall rates.
// ----------------------------------------------------------------------------

module tb_life_cellular_automaton_grid_core;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 8;
    localparam int SETTLE       = 16;     // extra wait once every result has arrived
    localparam int HOLD_CYCLES  = 250;    // long receiver hold-off
    localparam int IDLE_LIMIT   = 20000;  // several full-grid sweeps without a transfer
    localparam int LIVE_SAT     = (1 << lcag_pkg::CNT_W) - 1;

    // ------------------------------------------------------------------------
    // clock, reset and block connections
    // ------------------------------------------------------------------------
    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           in_valid = 1'b0;
    lcag_pkg::t_in                  in_item = '0;
    logic                           out_stall = 1'b0;
    logic                           cfg_valid = 1'b0;
    logic [lcag_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [lcag_pkg::AREA_W-1:0]    cfg_data = '0;
    logic                           o_in_stall;
    logic                           o_out_valid;
    lcag_pkg::t_out                 o_out_item;
    logic                           o_cfg_ready;

    wire in_fire  = i_rst_n && in_valid && !o_in_stall;
    wire out_fire = i_rst_n && o_out_valid && !out_stall;
    wire cfg_fire = i_rst_n && cfg_valid && o_cfg_ready;

    life_cellular_automaton_grid_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // bench state
    // ------------------------------------------------------------------------
    lcag_pkg::t_in  cell_ops_pending[$];   // operations waiting to be offered
    lcag_pkg::t_out gen_results_due[$];    // predicted results, oldest first
    logic in_fired = 1'b0;       // the offered operation was taken at the last edge

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int holds_asked    = 0;
    int holds_served   = 0;
    int hold_left      = 0;

    int ops_queued   = 0;
    int results_seen = 0;
    int steps_taken  = 0;
    int area_writes  = 0;
    int error_count  = 0;
    int quiet_cycles = 0;

    // own copy of the grid and the area registers
    logic [lcag_pkg::GRID_COLS-1:0] life_grid [lcag_pkg::GRID_ROWS];
    int                             live_total = 0;
    logic [lcag_pkg::AREA_W-1:0]    area_w = lcag_pkg::AREA_RESET;
    logic [lcag_pkg::AREA_W-1:0]    area_h = lcag_pkg::AREA_RESET;

    initial begin
        for (int r = 0; r < lcag_pkg::GRID_ROWS; r++)
            life_grid[r] = '0;
    end

    // ------------------------------------------------------------------------
    // grid prediction
    // ------------------------------------------------------------------------
    // register values above the grid size saturate at the grid size
    function automatic int area_cols();
        return (int'(area_w) > lcag_pkg::GRID_COLS) ? lcag_pkg::GRID_COLS : int'(area_w);
    endfunction

    function automatic int area_rows();
        return (int'(area_h) > lcag_pkg::GRID_ROWS) ? lcag_pkg::GRID_ROWS : int'(area_h);
    endfunction

    // kill everything outside the active area and recount
    function automatic void trim_to_area();
        int n;
        n = 0;
        for (int r = 0; r < lcag_pkg::GRID_ROWS; r++)
            for (int c = 0; c < lcag_pkg::GRID_COLS; c++) begin
                if (r >= area_rows() || c >= area_cols())
                    life_grid[r][c] = 1'b0;
                n += life_grid[r][c];
            end
        live_total = n;
    endfunction

    // one synchronous B3/S23 generation, returns whether any cell flipped
    function automatic bit next_generation();
        logic [lcag_pkg::GRID_COLS-1:0] next_rows [lcag_pkg::GRID_ROWS];
        int h, w, k, n;
        bit diff;
        h = area_rows();
        w = area_cols();
        n = 0;
        diff = 1'b0;
        for (int r = 0; r < lcag_pkg::GRID_ROWS; r++)
            next_rows[r] = '0;
        for (int r = 0; r < h; r++)
            for (int c = 0; c < w; c++) begin
                k = 0;
                for (int dr = -1; dr <= 1; dr++)
                    for (int dc = -1; dc <= 1; dc++)
                        if ((dr != 0 || dc != 0) && r + dr >= 0 && r + dr < h
                                && c + dc >= 0 && c + dc < w)
                            k += life_grid[r + dr][c + dc];
                if (life_grid[r][c])
                    next_rows[r][c] = (k == 2 || k == 3);
                else
                    next_rows[r][c] = (k == 3);
                n += next_rows[r][c];
                if (next_rows[r][c] != life_grid[r][c])
                    diff = 1'b1;
            end
        // a step with no change leaves the grid untouched
        if (diff) begin
            for (int r = 0; r < lcag_pkg::GRID_ROWS; r++)
                life_grid[r] = next_rows[r];
            live_total = n;
        end
        return diff;
    endfunction

    function automatic lcag_pkg::t_out life_predict(input lcag_pkg::t_in op);
        lcag_pkg::t_out res;
        bit             hit;
        res = '0;
        hit = int'(op.cell_row) < area_rows() && int'(op.cell_col) < area_cols();
        case (op.action)
            lcag_pkg::ACT_WRITE: begin
                // writes outside the area are dropped
                if (hit && life_grid[op.cell_row][op.cell_col] != op.cell_value) begin
                    life_grid[op.cell_row][op.cell_col] = op.cell_value;
                    live_total += op.cell_value ? 1 : -1;
                end
            end
            lcag_pkg::ACT_CLEAR: begin
                for (int r = 0; r < lcag_pkg::GRID_ROWS; r++)
                    life_grid[r] = '0;
                live_total = 0;
            end
            lcag_pkg::ACT_STEP: res.changed = next_generation();
            lcag_pkg::ACT_READ: ;  // read only
        endcase
        res.read_value = hit ? life_grid[op.cell_row][op.cell_col] : 1'b0;
        res.live_count = (live_total > LIVE_SAT) ? lcag_pkg::CNT_W'(LIVE_SAT)
                                                 : lcag_pkg::CNT_W'(live_total);
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // driver: offers queued operations, holds a stalled transfer unchanged
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_fired) begin
            if (cell_ops_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                in_item  <= cell_ops_pending.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver stall, with a long hold-off whenever the stimulus asks for one
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (holds_asked != holds_served) begin
            out_stall    <= 1'b1;
            hold_left    <= HOLD_CYCLES;
            holds_served <= holds_served + 1;
        end else begin
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // monitor: predicts on every operation transfer, checks every result
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        lcag_pkg::t_out want;
        in_fired <= in_fire;
        if (cfg_fire) begin
            if (cfg_index == lcag_pkg::CFG_WIDTH)
                area_w = cfg_data;
            else
                area_h = cfg_data;
            trim_to_area();
            area_writes++;
        end
        if (out_fire) begin
            if (gen_results_due.size() == 0) begin
                $error("result transfer with no operation outstanding");
                error_count++;
            end else begin
                want = gen_results_due.pop_front();
                results_seen++;
                if (o_out_item.read_value !== want.read_value) begin
                    $error("read_value: expected %0d, got %0d",
                           want.read_value, o_out_item.read_value);
                    error_count++;
                end
                if (o_out_item.changed !== want.changed) begin
                    $error("changed: expected %0d, got %0d",
                           want.changed, o_out_item.changed);
                    error_count++;
                end
                if (o_out_item.live_count !== want.live_count) begin
                    $error("live_count: expected %0d, got %0d",
                           want.live_count, o_out_item.live_count);
                    error_count++;
                end
            end
        end
        if (in_fire) begin
            if (in_item.action == lcag_pkg::ACT_STEP)
                steps_taken++;
            gen_results_due.push_back(life_predict(in_item));
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || in_fire || out_fire || cfg_fire)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("timeout: %0d cycles without a transfer, %0d results still due",
                     quiet_cycles, gen_results_due.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    task automatic offer(input logic [lcag_pkg::ACT_W-1:0] act, input int row,
                         input int col, input bit val);
        lcag_pkg::t_in op;
        op.action     = act;
        op.cell_row   = lcag_pkg::ROW_W'(row);
        op.cell_col   = lcag_pkg::COL_W'(col);
        op.cell_value = val;
        cell_ops_pending.push_back(op);
        ops_queued++;
    endtask

    // mostly writes of live cells inside the area, interleaved with steps,
    // so that patterns form and evolve; some traffic lands anywhere
    task automatic offer_random(input int rows, input int cols, input int step_pct);
        int pick, r, c;
        logic [lcag_pkg::ACT_W-1:0] act;
        pick = $urandom_range(99);
        if (pick < step_pct)
            act = lcag_pkg::ACT_STEP;
        else if (pick < step_pct + 5)
            act = lcag_pkg::ACT_CLEAR;
        else if (pick < step_pct + 60)
            act = lcag_pkg::ACT_WRITE;
        else
            act = lcag_pkg::ACT_READ;
        if (rows > 0 && cols > 0 && $urandom_range(99) < 80) begin
            r = $urandom_range(rows - 1);
            c = $urandom_range(cols - 1);
        end else begin
            r = $urandom_range(lcag_pkg::GRID_ROWS - 1);
            c = $urandom_range(lcag_pkg::GRID_COLS - 1);
        end
        if (act == lcag_pkg::ACT_WRITE)
            offer(act, r, c, $urandom_range(99) < 75);
        else
            offer(act, r, c, $urandom_range(1));
    endtask

    // sender holds back until every outstanding result has arrived
    task automatic drain_results();
        while (results_seen != ops_queued)
            @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_area(input logic [lcag_pkg::CFG_IDX_W-1:0] idx, input int val);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= lcag_pkg::AREA_W'(val);
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input int width_val, input int height_val, input int send_pct,
                             input int recv_pct, input int n_ops, input int step_pct,
                             input bit long_hold);
        int rows, cols;
        rows = (height_val > lcag_pkg::GRID_ROWS) ? lcag_pkg::GRID_ROWS : height_val;
        cols = (width_val > lcag_pkg::GRID_COLS) ? lcag_pkg::GRID_COLS : width_val;
        drain_results();
        write_area(lcag_pkg::CFG_WIDTH, width_val);
        write_area(lcag_pkg::CFG_HEIGHT, height_val);
        @(posedge i_clk);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        // receiver holds off while the sender keeps offering, so the core fills
        if (long_hold)
            holds_asked++;
        repeat (n_ops) offer_random(rows, cols, step_pct);
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part on the full grid straight after reset
        offer(lcag_pkg::ACT_READ,  0,  0,  1'b0);   // empty grid reads dead
        offer(lcag_pkg::ACT_STEP,  0,  0,  1'b0);   // step on an empty grid changes nothing
        offer(lcag_pkg::ACT_WRITE, 63, 63, 1'b1);   // far corner
        offer(lcag_pkg::ACT_WRITE, 0,  0,  1'b1);   // near corner
        offer(lcag_pkg::ACT_READ,  63, 63, 1'b0);
        offer(lcag_pkg::ACT_WRITE, 0,  0,  1'b1);   // rewrite of a live cell keeps the count
        offer(lcag_pkg::ACT_WRITE, 0,  0,  1'b0);
        offer(lcag_pkg::ACT_WRITE, 10, 10, 1'b1);   // blinker
        offer(lcag_pkg::ACT_WRITE, 10, 11, 1'b1);
        offer(lcag_pkg::ACT_WRITE, 10, 12, 1'b1);
        offer(lcag_pkg::ACT_STEP,  9,  11, 1'b0);
        offer(lcag_pkg::ACT_READ,  9,  11, 1'b0);
        offer(lcag_pkg::ACT_STEP,  10, 10, 1'b1);
        offer(lcag_pkg::ACT_READ,  10, 10, 1'b0);
        offer(lcag_pkg::ACT_CLEAR, 10, 11, 1'b1);
        offer(lcag_pkg::ACT_READ,  10, 11, 1'b0);
        offer(lcag_pkg::ACT_WRITE, 5,  5,  1'b0);   // killing a dead cell
        offer(lcag_pkg::ACT_WRITE, 62, 62, 1'b1);   // still life block in the corner
        offer(lcag_pkg::ACT_WRITE, 62, 63, 1'b1);
        offer(lcag_pkg::ACT_WRITE, 63, 62, 1'b1);
        offer(lcag_pkg::ACT_WRITE, 63, 63, 1'b1);
        offer(lcag_pkg::ACT_STEP,  63, 63, 1'b0);   // live grid, no change
        offer(lcag_pkg::ACT_READ,  63, 63, 1'b1);

        // random phases: shrinking to 8 by 8 kills the corner block first
        run_phase(8,   8,   0,  0,  20, 25, 1'b0);
        run_phase(1,   64,  55, 0,  15, 20, 1'b0);
        run_phase(64,  1,   0,  55, 15, 20, 1'b0);
        run_phase(0,   12,  37, 37, 10, 20, 1'b0);  // empty area, no columns
        run_phase(127, 0,   0,  0,  8,  20, 1'b0);  // empty area, no rows
        run_phase(127, 127, 37, 37, 20, 10, 1'b0);  // saturates at the grid size
        run_phase(10,  7,   0,  0,  20, 15, 1'b1);
        run_phase(6,   9,   37, 37, 15, 25, 1'b0);

        drain_results();
        $display("%0d cell operations checked, %0d of them generation steps,",
                 results_seen, steps_taken);
        $display("over %0d area register writes from empty to saturated", area_writes);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
